FILE: src/lgcw_pkg.sv
// shared types and constants for the grid cell walk
`default_nettype none
package lgcw_pkg;

  localparam int INT_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MAX_CELLS_DEF = 64;
  localparam int CELL_W        = 16;
  localparam int AXES          = 3;

  typedef struct packed {
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [CELL_W-1:0] z;
  } cell_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_PUSH_START,
    S_SEL,
    S_CMP1,
    S_CMP2,
    S_CMP3,
    S_PICK,
    S_IMUL,
    S_IDIV_GO,
    S_IDIV_WAIT,
    S_PUSH_CROSS,
    S_PUSH_END,
    S_EMIT_RD,
    S_EMIT_LD,
    S_ERR
  } state_t;

endpackage
`default_nettype wire

FILE: src/lgcw_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module lgcw_div #(
  parameter int W = lgcw_pkg::INT_BITS_DEF + lgcw_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*W-1:0]        dividend,
  input  logic [W-1:0]          divisor,
  output lgcw_pkg::div_stat_t   stat,
  output logic [W-1:0]          quotient
);
  import lgcw_pkg::*;

  localparam int SW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  low;
  logic [SW-1:0] steps;
  logic          done;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  // dividend high half is below the divisor, so the quotient fits W bits
  assign shifted = {rem, low[W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= dividend[2*W-1:W];
        low   <= dividend[W-1:0];
        steps <= SW'(W);
      end else if (steps != '0) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          low <= {low[W-2:0], 1'b1};
        end else begin
          rem <= shifted[W-1:0];
          low <= {low[W-2:0], 1'b0};
        end
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = (steps != '0);
  assign stat.done = done;
  assign quotient  = low;

endmodule
`default_nettype wire

FILE: src/lgcw_buf.sv
// cell buffer, one write port and one registered read port
`default_nettype none
module lgcw_buf #(
  parameter int DEPTH = lgcw_pkg::MAX_CELLS_DEF,
  parameter int AW    = $clog2(lgcw_pkg::MAX_CELLS_DEF)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  lgcw_pkg::cell_t     wdata,
  input  logic [AW-1:0]       raddr,
  output lgcw_pkg::cell_t     rdata
);
  import lgcw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/line_grid_cell_walk_core.sv
// top level: grid cell walk sequencer with shared multiplier and divider
//
// Each accepted item is a target point in signed fixed point (INT_BITS
// integer bits, FRAC_BITS fraction bits). The block walks the segment from
// the previous point to the target, orders the unit-plane crossings along
// the line, floors every point to a grid cell and lists the distinct
// consecutive cells, the final one marked by last_cell. A move needing more
// than MAX_CELLS cells gives one item with too_long and last_cell set and
// zero cells. The previous point is always replaced by the target. Timing:
// in_stall is high from the cycle after acceptance until the last result
// is loaded into the output register. Per crossing, the sequencer picks the
// next axis in S_SEL, running every pairwise order compare through S_CMP1,
// S_CMP2 and S_CMP3 on the one shared multiplier, then for each of the two
// other axes does one multiply and a divider pass; the buffered cells then
// leave one at a time, each read in S_EMIT_RD and loaded in S_EMIT_LD.
`default_nettype none
module line_grid_cell_walk_core #(
  parameter int INT_BITS  = lgcw_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = lgcw_pkg::FRAC_BITS_DEF,
  parameter int MAX_CELLS = lgcw_pkg::MAX_CELLS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]    target_x,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]    target_y,
  input  logic signed [INT_BITS+FRAC_BITS-1:0]    target_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [lgcw_pkg::CELL_W-1:0]      cell_x,
  output logic signed [lgcw_pkg::CELL_W-1:0]      cell_y,
  output logic signed [lgcw_pkg::CELL_W-1:0]      cell_z,
  output logic                                    last_cell,
  output logic                                    too_long
);
  import lgcw_pkg::*;

  localparam int IN_W = INT_BITS + FRAC_BITS;
  localparam int VW   = IN_W + 2;          // working width for positions
  localparam int PW   = 2 * IN_W;          // product width
  localparam int AW   = $clog2(MAX_CELLS);
  localparam int CW   = $clog2(MAX_CELLS + 1);
  localparam logic [VW-1:0] UNIT = VW'(1) << FRAC_BITS;

  // lower 16 bits of a sign extended floor
  function automatic logic [CELL_W-1:0] to_cell(input logic signed [VW-1:0] v);
    logic [VW+CELL_W-1:0] t;
    t = {{CELL_W{v[VW-1]}}, v};
    return t[CELL_W-1:0];
  endfunction

  state_t state, state_next;

  // per-axis lanes
  logic signed [VW-1:0] p0   [AXES];   // previous point, the move start
  logic signed [VW-1:0] p1   [AXES];   // move target
  logic signed [VW-1:0] np   [AXES];   // position of the next plane crossing
  logic signed [VW-1:0] pt   [AXES];   // point being pushed
  logic signed [VW-1:0] lastf[AXES];   // floor of the last stored cell
  logic [IN_W-1:0]      absd [AXES];
  logic                 dneg [AXES];
  logic                 act  [AXES];

  logic [1:0]    k;        // axis under examination
  logic [1:0]    best;     // earliest crossing so far
  logic          has_best;
  logic [1:0]    b;        // axis being interpolated
  logic [CW-1:0] cnt;
  logic [AW-1:0] idx;

  logic [IN_W-1:0] mul_a, mul_b;
  logic [PW-1:0]   mul_q, cmp_hold;

  div_stat_t       dstat;
  logic [IN_W-1:0] quot;
  logic            div_start;

  cell_t           wcell, rcell;
  logic            mem_we;
  logic            out_free, out_load, is_last;

  // setup values from start and target
  logic signed [VW-1:0] s_d   [AXES];
  logic signed [VW-1:0] s_np  [AXES];
  logic signed [VW-1:0] s_ng  [AXES];
  logic signed [VW-1:0] s_cl  [AXES];
  logic signed [VW-1:0] s_ad  [AXES];
  logic                 s_act [AXES];

  // distance from start to next crossing, per axis
  logic signed [VW-1:0] n_d   [AXES];
  logic signed [VW-1:0] n_ab  [AXES];
  logic [IN_W-1:0]      numv  [AXES];

  logic signed [VW-1:0] cf    [AXES];
  logic signed [VW-1:0] np_adv;
  logic                 act_adv;
  logic signed [VW-1:0] qs;
  logic                 same, full, push_st, push_over;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      s_d[a]   = p1[a] - p0[a];
      s_ng[a]  = -p0[a];
      s_cl[a]  = -(s_ng[a] >>> FRAC_BITS);
      s_ad[a]  = s_d[a][VW-1] ? -s_d[a] : s_d[a];
      if (s_d[a][VW-1]) begin
        s_np[a]  = (s_cl[a] - VW'(1)) <<< FRAC_BITS;
        s_act[a] = s_np[a] > p1[a];
      end else begin
        s_np[a]  = ((p0[a] >>> FRAC_BITS) + VW'(1)) <<< FRAC_BITS;
        s_act[a] = (s_d[a] != '0) && (s_np[a] < p1[a]);
      end
      n_d[a]  = np[a] - p0[a];
      n_ab[a] = n_d[a][VW-1] ? -n_d[a] : n_d[a];
      numv[a] = n_ab[a][IN_W-1:0];
      cf[a]   = pt[a] >>> FRAC_BITS;
    end
  end

  assign np_adv  = dneg[best] ? np[best] - $signed(UNIT) : np[best] + $signed(UNIT);
  assign act_adv = dneg[best] ? (np_adv > p1[best]) : (np_adv < p1[best]);
  assign qs      = $signed({2'b00, quot});

  // merge with the previous cell, detect the cell limit
  assign same      = (cnt != '0) && (cf[0] == lastf[0]) && (cf[1] == lastf[1])
                     && (cf[2] == lastf[2]);
  assign full      = (cnt == CW'(MAX_CELLS));
  assign push_st   = (state == S_PUSH_START) || (state == S_PUSH_CROSS)
                     || (state == S_PUSH_END);
  assign push_over = !same && full;

  assign wcell.x = to_cell(cf[0]);
  assign wcell.y = to_cell(cf[1]);
  assign wcell.z = to_cell(cf[2]);

  assign out_free = !out_valid || !out_stall;
  assign is_last  = (CW'(idx) + CW'(1)) == cnt;

  // multiplier operand select
  always_comb begin
    mul_a = numv[k];
    mul_b = absd[best];
    case (state)
      S_CMP1: begin
        mul_a = numv[k];
        mul_b = absd[best];
      end
      S_CMP2: begin
        mul_a = numv[best];
        mul_b = absd[k];
      end
      S_IMUL: begin
        mul_a = numv[best];
        mul_b = absd[b];
      end
      default: begin
        mul_a = numv[k];
        mul_b = absd[best];
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_SETUP;
      S_SETUP:      state_next = S_PUSH_START;
      S_PUSH_START: state_next = S_SEL;
      S_SEL: begin
        if (act[k] && has_best) state_next = S_CMP1;
        else if (k == 2'd2)     state_next = S_PICK;
      end
      S_CMP1:       state_next = S_CMP2;
      S_CMP2:       state_next = S_CMP3;
      S_CMP3:       state_next = (k == 2'd2) ? S_PICK : S_SEL;
      S_PICK:       state_next = has_best ? S_IMUL : S_PUSH_END;
      S_IMUL: begin
        if (b != best)      state_next = S_IDIV_GO;
        else if (b == 2'd2) state_next = S_PUSH_CROSS;
      end
      S_IDIV_GO:    state_next = S_IDIV_WAIT;
      S_IDIV_WAIT: begin
        if (dstat.done) state_next = (b == 2'd2) ? S_PUSH_CROSS : S_IMUL;
      end
      S_PUSH_CROSS: state_next = push_over ? S_ERR : S_SEL;
      S_PUSH_END:   state_next = push_over ? S_ERR : S_EMIT_RD;
      S_EMIT_RD:    state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        if (out_free) state_next = is_last ? S_IDLE : S_EMIT_RD;
      end
      S_ERR:        if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_IDIV_GO);
    mem_we    = push_st && !same && !full;
    out_load  = ((state == S_EMIT_LD) || (state == S_ERR)) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        p0[a] <= '0;
      end
      cnt <= '0;
    end else begin
      mul_q <= PW'(mul_a) * PW'(mul_b);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            p1[0] <= VW'(target_x);
            p1[1] <= VW'(target_y);
            p1[2] <= VW'(target_z);
          end
        end
        S_SETUP: begin
          for (int a = 0; a < AXES; a++) begin
            np[a]   <= s_np[a];
            act[a]  <= s_act[a];
            dneg[a] <= s_d[a][VW-1];
            absd[a] <= s_ad[a][IN_W-1:0];
            pt[a]   <= p0[a];
          end
          cnt      <= '0;
          k        <= '0;
          has_best <= 1'b0;
        end
        S_SEL: begin
          if (act[k] && !has_best) begin
            best     <= k;
            has_best <= 1'b1;
          end
          if (!(act[k] && has_best) && k != 2'd2) begin
            k <= k + 2'd1;
          end
        end
        S_CMP2: cmp_hold <= mul_q;
        S_CMP3: begin
          // strictly earlier wins, so ties keep axis order
          if (cmp_hold < mul_q) best <= k;
          if (k != 2'd2) k <= k + 2'd1;
        end
        S_PICK: begin
          b <= '0;
          if (!has_best) begin
            for (int a = 0; a < AXES; a++) begin
              pt[a] <= p1[a];
            end
          end
        end
        S_IMUL: begin
          if (b == best) begin
            pt[b] <= np[best];
            if (b != 2'd2) b <= b + 2'd1;
          end
        end
        S_IDIV_WAIT: begin
          if (dstat.done) begin
            pt[b] <= dneg[b] ? p0[b] - qs : p0[b] + qs;
            if (b != 2'd2) b <= b + 2'd1;
          end
        end
        S_PUSH_CROSS: begin
          np[best]  <= np_adv;
          act[best] <= act_adv;
          k         <= '0;
          has_best  <= 1'b0;
        end
        S_PUSH_END: idx <= '0;
        S_EMIT_LD: begin
          if (out_free) begin
            idx <= idx + AW'(1);
            if (is_last) begin
              for (int a = 0; a < AXES; a++) begin
                p0[a] <= p1[a];
              end
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            for (int a = 0; a < AXES; a++) begin
              p0[a] <= p1[a];
            end
          end
        end
        default: begin
        end
      endcase
      if (mem_we) begin
        for (int a = 0; a < AXES; a++) begin
          lastf[a] <= cf[a];
        end
        cnt <= cnt + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (out_load) begin
      if (state == S_ERR) begin
        cell_x    <= '0;
        cell_y    <= '0;
        cell_z    <= '0;
        last_cell <= 1'b1;
        too_long  <= 1'b1;
      end else begin
        cell_x    <= rcell.x;
        cell_y    <= rcell.y;
        cell_z    <= rcell.z;
        last_cell <= is_last;
        too_long  <= 1'b0;
      end
    end
  end

  lgcw_div #(.W(IN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_q),
    .divisor  (absd[best]),
    .stat     (dstat),
    .quotient (quot)
  );

  lgcw_buf #(.DEPTH(MAX_CELLS), .AW(AW)) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt[AW-1:0]),
    .wdata (wcell),
    .raddr (idx),
    .rdata (rcell)
  );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the grid cell walk: directed table, then random moves against a predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  IN_W      = lgcw_pkg::INT_BITS_DEF + lgcw_pkg::FRAC_BITS_DEF;
  localparam int  FRAC      = lgcw_pkg::FRAC_BITS_DEF;
  localparam int  CELL_CAP  = lgcw_pkg::MAX_CELLS_DEF;
  localparam longint UNIT   = longint'(1) << FRAC;
  localparam longint IN_MIN = -(longint'(1) << (IN_W - 1));
  localparam longint IN_MAX = (longint'(1) << (IN_W - 1)) - 1;
  localparam int  N_RANDOM  = 262;
  localparam int  TAIL_CYC  = 200;
  localparam int  HOLD_CYC  = 400;
  localparam longint CYC_LIMIT = 20000000;

  // one cell as it leaves the block
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
    logic        tl;
  } cell_item_t;

  // directed row: target, and a typed-in result where it reads off directly
  typedef struct {
    int  x, y, z;
    bit  typed;
    int  ex, ey, ez;
    bit  etl;
  } move_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] cell_x, cell_y, cell_z;
  logic last_cell, too_long;

  line_grid_cell_walk_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .last_cell(last_cell), .too_long(too_long)
  );

  always #6 clk = ~clk;

  cell_item_t cells_due[$];
  longint     pos_x = 0, pos_y = 0, pos_z = 0;   // predictor copy of the previous point
  longint     walk_c[CELL_CAP][3];
  int         walk_n;
  bit         walk_over;
  int         errors = 0;
  longint     cyc = 0;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  move_row_t  rows[19];

  function automatic longint fdiv(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q -= 1;
    return q;
  endfunction

  // floor a point to its cell and append it unless it repeats the last one
  task automatic add_cell(longint px, longint py, longint pz);
    longint c0, c1, c2;
    c0 = fdiv(px, UNIT);
    c1 = fdiv(py, UNIT);
    c2 = fdiv(pz, UNIT);
    if (walk_n > 0 && walk_c[walk_n-1][0] == c0 && walk_c[walk_n-1][1] == c1 &&
        walk_c[walk_n-1][2] == c2) return;
    if (walk_n >= CELL_CAP) begin
      walk_over = 1'b1;
      return;
    end
    walk_c[walk_n][0] = c0;
    walk_c[walk_n][1] = c1;
    walk_c[walk_n][2] = c2;
    walk_n++;
  endtask

  // walk one move from the stored point to the target; queue cells if asked
  task automatic walk_move(input longint tx, ty, tz, input bit queue_it);
    longint p0[3], p1[3], nc[3], dir[3], pt[3];
    bit act[3];
    int best;
    longint bnum, bden, num, den, pos, span;
    cell_item_t c;
    p0 = '{pos_x, pos_y, pos_z};
    p1 = '{tx, ty, tz};
    walk_n = 0;
    walk_over = 1'b0;
    for (int a = 0; a < 3; a++) begin
      act[a] = 1'b0; dir[a] = 0; nc[a] = 0;
      if (p1[a] > p0[a]) begin
        dir[a] = 1;
        nc[a] = fdiv(p0[a], UNIT) + 1;
        act[a] = nc[a] * UNIT < p1[a];
      end else if (p1[a] < p0[a]) begin
        dir[a] = -1;
        nc[a] = -fdiv(-p0[a], UNIT) - 1;
        act[a] = nc[a] * UNIT > p1[a];
      end
    end
    add_cell(p0[0], p0[1], p0[2]);
    while (!walk_over) begin
      best = -1; bnum = 0; bden = 1;
      // nearest crossing along the line; ties keep axis order x, y, z
      for (int a = 0; a < 3; a++) begin
        if (!act[a]) continue;
        num = (nc[a] * UNIT - p0[a]) * dir[a];
        den = (p1[a] - p0[a]) * dir[a];
        if (best < 0 || num * bden < bnum * den) begin
          best = a; bnum = num; bden = den;
        end
      end
      if (best < 0) break;
      pos = nc[best] * UNIT;
      span = p1[best] - p0[best];
      for (int b = 0; b < 3; b++)
        pt[b] = (b == best) ? pos : p0[b] + ((pos - p0[best]) * (p1[b] - p0[b])) / span;
      add_cell(pt[0], pt[1], pt[2]);
      nc[best] += dir[best];
      act[best] = (dir[best] > 0) ? (nc[best] * UNIT < p1[best]) : (nc[best] * UNIT > p1[best]);
    end
    if (!walk_over) add_cell(p1[0], p1[1], p1[2]);
    pos_x = tx; pos_y = ty; pos_z = tz;
    if (!queue_it) return;
    if (walk_over) begin
      cells_due.push_back('{16'h0, 16'h0, 16'h0, 1'b1, 1'b1});
      return;
    end
    for (int r = 0; r < walk_n; r++) begin
      c.x = walk_c[r][0][15:0];
      c.y = walk_c[r][1][15:0];
      c.z = walk_c[r][2][15:0];
      c.last = (r == walk_n - 1);
      c.tl = 1'b0;
      cells_due.push_back(c);
    end
  endtask

  // present one target, hold it until taken, then predict its cells
  task automatic send_target(input longint tx, ty, tz, input bit typed, input cell_item_t want);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    target_x = tx[IN_W-1:0];
    target_y = ty[IN_W-1:0];
    target_z = tz[IN_W-1:0];
    do @(posedge clk); while (in_stall);
    walk_move(tx, ty, tz, !typed);
    if (typed) cells_due.push_back(want);
    @(negedge clk);
  endtask

  function automatic longint clamp_in(longint v);
    return (v < IN_MIN) ? IN_MIN : (v > IN_MAX) ? IN_MAX : v;
  endfunction

  function automatic longint full_rand();
    return longint'($signed(24'($urandom)));
  endfunction

  // free-running cycle count and watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: compare each taken cell with the oldest one predicted
  always @(posedge clk) begin
    cell_item_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{cell_x, cell_y, cell_z, last_cell, too_long};
      if (cells_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected cell %p", got);
      end else begin
        want = cells_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("cell mismatch: exp x=%0d y=%0d z=%0d last=%b tl=%b got x=%0d y=%0d z=%0d last=%b tl=%b",
                     $signed(want.x), $signed(want.y), $signed(want.z), want.last, want.tl,
                     $signed(got.x), $signed(got.y), $signed(got.z), got.last, got.tl);
        end
      end
    end
  end

  // result side stall: random, plus one long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYC;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = idle_on && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin
    longint tx, ty, tz, sp;
    int k;
    cell_item_t want;
    // directed moves; typed rows are the reset point, zero-length moves and too-long moves
    rows[0]  = '{0, 0, 0, 1, 0, 0, 0, 0};
    rows[1]  = '{128, 64, 32, 0, 0, 0, 0, 0};
    rows[2]  = '{778, 0, 0, 0, 0, 0, 0, 0};
    rows[3]  = '{778, -517, 0, 0, 0, 0, 0, 0};
    rows[4]  = '{0, 0, 0, 0, 0, 0, 0, 0};
    rows[5]  = '{512, 512, 512, 0, 0, 0, 0, 0};          // crossings tie on all axes
    rows[6]  = '{-512, -512, -512, 0, 0, 0, 0, 0};
    rows[7]  = '{-1, -1, -1, 0, 0, 0, 0, 0};
    rows[8]  = '{8388607, 8388607, 8388607, 1, 0, 0, 0, 1};
    rows[9]  = '{8388607, 8388607, 8388607, 1, 32767, 32767, 32767, 0};
    rows[10] = '{-8388608, -8388608, -8388608, 1, 0, 0, 0, 1};
    rows[11] = '{-8388608, -8388608, -8388608, 1, -32768, -32768, -32768, 0};
    rows[12] = '{-8384512, -8388608, -8388508, 0, 0, 0, 0, 0};
    rows[13] = '{0, 0, 0, 1, 0, 0, 0, 1};
    rows[14] = '{16129, 0, 0, 0, 0, 0, 0, 0};             // exactly the cell cap
    rows[15] = '{0, 0, 0, 0, 0, 0, 0, 0};
    rows[16] = '{16385, 0, 0, 1, 0, 0, 0, 1};             // one cell over the cap
    rows[17] = '{16385, 300, -300, 0, 0, 0, 0, 0};
    rows[18] = '{16000, 700, -900, 0, 0, 0, 0, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      want = '{rows[i].ex[15:0], rows[i].ey[15:0], rows[i].ez[15:0], 1'b1, rows[i].etl};
      send_target(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, want);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 40) hold_req = 1'b1;                      // block fills while sender keeps offering
      idle_on = !(k >= 100 && k < 160);                  // stretch with no idling
      if (k == 180) begin
        // sender waits for the block to drain completely
        in_valid = 1'b0;
        wait (cells_due.size() == 0);
        @(negedge clk);
      end
      case ($urandom_range(99)) inside
        [0:7]: begin
          tx = full_rand(); ty = full_rand(); tz = full_rand();
        end
        [8:12]: begin
          tx = pos_x; ty = pos_y; tz = pos_z;
        end
        [13:19]: begin
          tx = clamp_in(pos_x + $urandom_range(255) - 128);
          ty = clamp_in(pos_y + $urandom_range(255) - 128);
          tz = clamp_in(pos_z + $urandom_range(255) - 128);
        end
        default: begin
          sp = ($urandom_range(99) < 80) ? 1024 : 6000;
          tx = clamp_in(pos_x + longint'($urandom_range(2 * sp)) - sp);
          ty = clamp_in(pos_y + longint'($urandom_range(2 * sp)) - sp);
          tz = clamp_in(pos_z + longint'($urandom_range(2 * sp)) - sp);
        end
      endcase
      send_target(tx, ty, tz, 1'b0, '0);
    end
    in_valid = 1'b0;

    wait (cells_due.size() == 0);
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0 && cells_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
